>>> design/msq_pkg.sv
package msq_pkg;

    localparam int MAX_SIZE_DEF = 32;

    localparam int SIZE_W  = 6;
    localparam int IDX_W   = 5;
    localparam int ELEM_W  = 8;
    localparam int PROD_W  = 21;
    localparam int TOTAL_W = 32;
    localparam int VALUE_W = 31;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd30;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_CALC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic RES_TOTAL = 1'b0;
    localparam logic RES_ENTRY = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  column;
        logic [ELEM_W-1:0] element;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic [VALUE_W-1:0] result_value;
    } t_out_word;

    // control that travels alongside the operand pair into the MAC
    typedef struct packed {
        logic clear;
        logic valid;
        logic last;
    } t_mac_ctl;

endpackage

>>> design/msq_mac.sv
module msq_mac #(
    parameter int ACC_W = 21,
    parameter int AW    = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msq_pkg::t_mac_ctl             i_ctl,
    input  logic [msq_pkg::ELEM_W-1:0]    i_a,
    input  logic [msq_pkg::ELEM_W-1:0]    i_b,
    input  logic [AW-1:0]                 i_addr,
    output logic                          o_busy,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [msq_pkg::PROD_W-1:0]    o_wr_data,
    output logic [msq_pkg::TOTAL_W-1:0]   o_total
);
    import msq_pkg::*;

    logic [2*ELEM_W-1:0] r_prod;
    logic                r_valid;
    logic                r_last;
    logic [AW-1:0]       r_addr;
    logic [ACC_W-1:0]    r_acc;
    logic [TOTAL_W-1:0]  r_total;

    logic [ACC_W-1:0]    sum;
    logic [PROD_W-1:0]   entry;

    assign sum   = r_acc + ACC_W'(r_prod);
    assign entry = PROD_W'(sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_total <= '0;
        end else begin
            r_valid <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc   <= '0;
                r_total <= '0;
            end else if (r_valid) begin
                if (r_last) begin
                    r_acc   <= '0;
                    r_total <= r_total + TOTAL_W'(entry);
                end else begin
                    r_acc <= sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_last <= i_ctl.last;
        r_addr <= i_addr;
    end

    assign o_busy    = r_valid;
    assign o_wr_en   = r_valid && r_last;
    assign o_wr_addr = r_addr;
    assign o_wr_data = entry;
    assign o_total   = r_total;

endmodule

>>> design/matrix_square_with_total.sv
// Square-matrix squarer with a grand total.
// Input channel (i_in_valid / o_in_stall) carries one command word:
//   load  - stores one source element; no result.
//   calc  - forms P = A * A over the active size, stores P, returns the
//           sum of all active entries (result_kind 0).
//   read  - returns one stored entry of P, or 0 outside the active size
//           (result_kind 1).
// Calc walks one multiply-accumulate per cycle through a single shared
// 8x8 multiplier fed by a two-read source memory, over every (i, j, k)
// within the active size, then drains the pipeline. The block stalls
// its input for the whole walk.
// Output channel (o_out_valid / i_out_stall) is a single output register;
// while a result is held under stall, loads are still taken but calc and
// read wait. The held word does not change under stall.
// i_cfg_we / i_cfg_data set the matrix size; write only while idle.
// After reset both memories, (2**ceil(log2(MAX_SIZE)))**2 entries each
// (1024 at the default), are cleared one entry per cycle, during which
// input is stalled; size writes are taken throughout.
module matrix_square_with_total #(
    parameter int MAX_SIZE = msq_pkg::MAX_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [msq_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  msq_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output msq_pkg::t_out_word          o_out_word
);
    import msq_pkg::*;

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int ACC_W = $clog2(MAX_SIZE * (2**ELEM_W - 1) * (2**ELEM_W - 1) + 1);
    localparam int CMP_W = ((NW > SIZE_W) ? NW : SIZE_W) + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_READ
    } t_state;

    t_state             r_state;
    logic [SIZE_W-1:0]  r_size;
    logic [AW-1:0]      r_clr;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic [IW-1:0]      r_k;
    logic               r_s1_valid;
    logic               r_s1_last;
    logic [AW-1:0]      r_s1_addr;
    logic               r_rd_ok;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic [ELEM_W-1:0]  r_src [DEPTH];
    logic [PROD_W-1:0]  r_prd [DEPTH];
    logic [ELEM_W-1:0]  r_qa;
    logic [ELEM_W-1:0]  r_qb;
    logic [PROD_W-1:0]  r_pq;

    logic [CMP_W-1:0]   size_ext;
    logic [NW-1:0]      n_act;
    logic               in_acc;
    logic               ld_ok;
    logic               rd_ok;
    logic [IW-1:0]      row_ix;
    logic [IW-1:0]      col_ix;
    logic               i_last;
    logic               j_last;
    logic               k_last;
    logic               clearing;

    logic               src_we;
    logic [AW-1:0]      src_wa;
    logic [ELEM_W-1:0]  src_wd;
    logic               prd_we;
    logic [AW-1:0]      prd_wa;
    logic [PROD_W-1:0]  prd_wd;

    t_mac_ctl           mac_ctl;
    logic               mac_busy;
    logic               mac_wr_en;
    logic [AW-1:0]      mac_wr_addr;
    logic [PROD_W-1:0]  mac_wr_data;
    logic [TOTAL_W-1:0] mac_total;

    // active size saturates at the storage size
    assign size_ext = CMP_W'(r_size);
    assign n_act    = (size_ext > CMP_W'(MAX_SIZE)) ? NW'(MAX_SIZE) : NW'(size_ext);

    assign o_in_stall = (r_state != ST_IDLE) ||
                        (r_out_valid && i_out_stall &&
                         (i_in_word.opcode == OP_CALC || i_in_word.opcode == OP_READ));
    assign in_acc = i_in_valid && !o_in_stall;

    assign ld_ok = (CMP_W'(i_in_word.row) < CMP_W'(MAX_SIZE)) &&
                   (CMP_W'(i_in_word.column) < CMP_W'(MAX_SIZE));
    assign rd_ok = (CMP_W'(i_in_word.row) < CMP_W'(n_act)) &&
                   (CMP_W'(i_in_word.column) < CMP_W'(n_act));
    assign row_ix = IW'(i_in_word.row);
    assign col_ix = IW'(i_in_word.column);

    assign i_last = (NW'(r_i) + NW'(1)) == n_act;
    assign j_last = (NW'(r_j) + NW'(1)) == n_act;
    assign k_last = (NW'(r_k) + NW'(1)) == n_act;

    assign clearing = (r_state == ST_CLEAR);

    // source memory: one write port, two read ports for row and column operands
    assign src_we = clearing || (in_acc && i_in_word.opcode == OP_LOAD && ld_ok);
    assign src_wa = clearing ? r_clr : {row_ix, col_ix};
    assign src_wd = clearing ? '0 : i_in_word.element;

    always_ff @(posedge i_clk) begin
        if (src_we) begin
            r_src[src_wa] <= src_wd;
        end
        r_qa <= r_src[{r_i, r_k}];
        r_qb <= r_src[{r_k, r_j}];
    end

    // product memory
    assign prd_we = clearing || mac_wr_en;
    assign prd_wa = clearing ? r_clr : mac_wr_addr;
    assign prd_wd = clearing ? '0 : mac_wr_data;

    always_ff @(posedge i_clk) begin
        if (prd_we) begin
            r_prd[prd_wa] <= prd_wd;
        end
        r_pq <= r_prd[{row_ix, col_ix}];
    end

    assign mac_ctl = '{clear: in_acc && (i_in_word.opcode == OP_CALC),
                       valid: r_s1_valid,
                       last:  r_s1_last};

    msq_mac #(
        .ACC_W (ACC_W),
        .AW    (AW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_a       (r_qa),
        .i_b       (r_qb),
        .i_addr    (r_s1_addr),
        .o_busy    (mac_busy),
        .o_wr_en   (mac_wr_en),
        .o_wr_addr (mac_wr_addr),
        .o_wr_data (mac_wr_data),
        .o_total   (mac_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_size      <= SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_s1_valid <= 1'b0;

            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_in_word.opcode)
                            OP_CALC: begin
                                r_i <= '0;
                                r_j <= '0;
                                r_k <= '0;
                                r_state <= (n_act == '0) ? ST_DRAIN : ST_CALC;
                            end
                            OP_READ: begin
                                r_rd_ok <= rd_ok;
                                r_state <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CALC: begin
                    r_s1_valid <= 1'b1;
                    r_s1_last  <= k_last;
                    r_s1_addr  <= {r_i, r_j};
                    if (k_last) begin
                        r_k <= '0;
                        if (j_last) begin
                            r_j <= '0;
                            if (i_last) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_i <= r_i + IW'(1);
                            end
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end else begin
                        r_k <= r_k + IW'(1);
                    end
                end
                ST_DRAIN: begin
                    // wait for the last entry to land in the total
                    if (!r_s1_valid && !mac_busy) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= '{result_kind:  RES_TOTAL,
                                         result_value: VALUE_W'(mac_total)};
                        r_state     <= ST_IDLE;
                    end
                end
                ST_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_word  <= '{result_kind:  RES_ENTRY,
                                     result_value: r_rd_ok ? VALUE_W'(r_pq) : '0};
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
